/* src/sdsf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sketch density sample filter.
// Used by every module under src; depends on nothing else.
package sdsf_pkg;

  // Default geometry of the count store
  localparam int N_EXP_DEF   = 4;
  localparam int REPS_DEF    = 4;
  localparam int BUCKETS_DEF = 1024;

  // Fixed field widths
  localparam int CMD_W   = 1;
  localparam int EXP_W   = 2;
  localparam int REP_W   = 2;
  localparam int HASH_W  = 32;
  localparam int LABEL_W = 64;
  localparam int CNT_W   = 32;
  localparam int TOTAL_W = 35;
  localparam int THR_W   = 32;

  // Stream packing
  localparam int IN_DATA_W  = HASH_W + LABEL_W;      // hash, label
  localparam int IN_USER_W  = CMD_W + EXP_W + REP_W; // cmd, experiment, repetition
  localparam int OUT_DATA_W = LABEL_W;               // label_out
  localparam int OUT_USER_W = EXP_W + 1;             // exp_out, keep

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b1;

  // Bucket remainder by reciprocal multiplication: cycles spent in the front end
  localparam int DIV_STEPS = 3;

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 4;

  // Control part of one queued command
  typedef struct packed {
    logic             is_clear;
    logic             rep_first;
    logic             rep_last;
    logic [EXP_W-1:0] exp;
  } item_ctl_t;

endpackage

/* src/sdsf_front.sv */
`timescale 1ns / 1ps
// Front end: accepts stream items, drops out-of-range adds, reduces the hash
// to a bucket and forms the store address. Depends on sdsf_pkg.
module sdsf_front #(
  parameter int N_EXP   = sdsf_pkg::N_EXP_DEF,
  parameter int REPS    = sdsf_pkg::REPS_DEF,
  parameter int BUCKETS = sdsf_pkg::BUCKETS_DEF,
  localparam int ROW_N  = N_EXP * REPS,
  localparam int ROW_W  = (ROW_N > 1) ? $clog2(ROW_N) : 1,
  localparam int ADDR_W = $clog2(ROW_N * BUCKETS)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sdsf_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [sdsf_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic                             sweep_busy,
  input  logic                             q_full,
  output logic                             q_push,
  output sdsf_pkg::item_ctl_t              q_ctl,
  output logic [ADDR_W-1:0]                q_addr,
  output logic [sdsf_pkg::LABEL_W-1:0]     q_label
);

  localparam int BKT_W = $clog2(BUCKETS);
  localparam bit BKT_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam int STEP_W = (sdsf_pkg::DIV_STEPS > 1) ? $clog2(sdsf_pkg::DIV_STEPS) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(sdsf_pkg::DIV_STEPS - 1);
  localparam int RCP_SH = sdsf_pkg::HASH_W + BKT_W;
  localparam logic [63:0] RCP_M =
    ((64'd1 << RCP_SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [sdsf_pkg::HASH_W-1:0] RCP_LO = RCP_M[sdsf_pkg::HASH_W-1:0];
  localparam logic RCP_HI = RCP_M[sdsf_pkg::HASH_W];
  localparam int PROD_W = 2 * sdsf_pkg::HASH_W + 1;

  localparam logic FS_IDLE = 1'b0;
  localparam logic FS_DIV  = 1'b1;

  logic                           fs_r, fs_nxt;
  logic [STEP_W-1:0]              step_r, step_nxt;
  logic [BKT_W-1:0]               rem_r, rem_nxt;
  logic [PROD_W-1:0]              prod_r, prod_nxt;
  logic [sdsf_pkg::HASH_W-1:0]    sh_r;
  sdsf_pkg::item_ctl_t            hold_ctl_r;
  logic [ROW_W-1:0]               hold_row_r;
  logic [sdsf_pkg::LABEL_W-1:0]   hold_label_r;

  logic [sdsf_pkg::CMD_W-1:0]     cmd;
  logic [sdsf_pkg::EXP_W-1:0]     exp_in;
  logic [sdsf_pkg::REP_W-1:0]     rep_in;
  logic [sdsf_pkg::HASH_W-1:0]    hash_in;
  logic [sdsf_pkg::LABEL_W-1:0]   label_in;
  sdsf_pkg::item_ctl_t            ctl_in;
  logic [ROW_W-1:0]               row_in, row_sel;
  logic [BKT_W-1:0]               bkt_sel;
  logic [2*sdsf_pkg::HASH_W-1:0]  mul_lo;
  logic [sdsf_pkg::HASH_W-1:0]    quo;
  logic                           accept, in_range, start_div;

  // Unpack the stream fields
  assign cmd      = in_tuser[0];
  assign exp_in   = in_tuser[2:1];
  assign rep_in   = in_tuser[4:3];
  assign hash_in  = in_tdata[31:0];
  assign label_in = in_tdata[95:32];

  // Classify the item
  assign in_range = (32'(exp_in) < 32'(N_EXP)) && (32'(rep_in) < 32'(REPS));
  assign row_in   = ROW_W'(32'(exp_in) * 32'(REPS) + 32'(rep_in));

  always_comb begin
    ctl_in.is_clear  = (cmd == sdsf_pkg::CMD_CLEAR);
    ctl_in.rep_first = (rep_in == '0);
    ctl_in.rep_last  = (32'(rep_in) == 32'(REPS - 1));
    ctl_in.exp       = exp_in;
  end

  // Take items only from idle, with queue room, outside a clearing pass
  assign in_tready = (fs_r == FS_IDLE) && !q_full && !sweep_busy;
  assign accept    = in_tvalid && in_tready;
  assign start_div = accept && !ctl_in.is_clear && in_range && !BKT_POW2;

  // Bucket remainder by reciprocal multiplication: product, then quotient and remainder
  always_comb begin
    mul_lo   = {{sdsf_pkg::HASH_W{1'b0}}, sh_r} * {{sdsf_pkg::HASH_W{1'b0}}, RCP_LO};
    prod_nxt = PROD_W'(mul_lo) +
               (RCP_HI ? {1'b0, sh_r, {sdsf_pkg::HASH_W{1'b0}}} : PROD_W'(0));
    quo      = sdsf_pkg::HASH_W'(prod_r >> RCP_SH);
    rem_nxt  = BKT_W'(sh_r - quo * sdsf_pkg::HASH_W'(BUCKETS));
  end

  // Select what goes into the queue
  always_comb begin
    q_push  = 1'b0;
    q_ctl   = ctl_in;
    row_sel = row_in;
    bkt_sel = hash_in[BKT_W-1:0];
    q_label = label_in;
    if (fs_r == FS_IDLE) begin
      if (accept && (ctl_in.is_clear || (in_range && BKT_POW2))) begin
        q_push = 1'b1;
      end
    end else begin
      q_ctl   = hold_ctl_r;
      row_sel = hold_row_r;
      bkt_sel = rem_r;
      q_label = hold_label_r;
      q_push  = (step_r == STEP_LAST);
    end
  end

  assign q_addr = ADDR_W'(32'(row_sel) * 32'(BUCKETS) + 32'(bkt_sel));

  // Sequencer next state
  always_comb begin
    fs_nxt   = fs_r;
    step_nxt = step_r;
    unique case (fs_r)
      FS_IDLE: begin
        step_nxt = '0;
        if (start_div) begin
          fs_nxt = FS_DIV;
        end
      end
      FS_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          fs_nxt = FS_IDLE;
        end
      end
      default: fs_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r   <= FS_IDLE;
      step_r <= '0;
    end else begin
      fs_r   <= fs_nxt;
      step_r <= step_nxt;
    end
  end

  // Hold the item and advance the remainder
  always_ff @(posedge clk) begin
    if (start_div) begin
      sh_r         <= hash_in;
      hold_ctl_r   <= ctl_in;
      hold_row_r   <= row_in;
      hold_label_r <= label_in;
    end else if (fs_r == FS_DIV) begin
      prod_r <= prod_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule

/* src/sdsf_queue.sv */
`timescale 1ns / 1ps
// Short first-word-fall-through queue between the front and back ends.
// Depends on sdsf_pkg for its default depth.
module sdsf_queue #(
  parameter int W     = 8,
  parameter int DEPTH = sdsf_pkg::Q_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty,
  output logic         full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue pushed while full");

endmodule

/* src/sdsf_back.sv */
`timescale 1ns / 1ps
// Back end: count store with clearing pass, read-modify-write of buckets,
// running total, keep decision and output register. Depends on sdsf_pkg.
module sdsf_back #(
  parameter int N_EXP   = sdsf_pkg::N_EXP_DEF,
  parameter int REPS    = sdsf_pkg::REPS_DEF,
  parameter int BUCKETS = sdsf_pkg::BUCKETS_DEF,
  localparam int DEPTH  = N_EXP * REPS * BUCKETS,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [sdsf_pkg::THR_W-1:0]       cfg_wr_data,
  input  logic                             q_empty,
  output logic                             q_pop,
  input  sdsf_pkg::item_ctl_t              q_ctl,
  input  logic [ADDR_W-1:0]                q_addr,
  input  logic [sdsf_pkg::LABEL_W-1:0]     q_label,
  output logic                             sweep_busy,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sdsf_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [sdsf_pkg::OUT_USER_W-1:0]  out_tuser
);

  localparam int LIM_W = sdsf_pkg::THR_W + $clog2(REPS);
  localparam int CMP_W = (LIM_W > sdsf_pkg::TOTAL_W) ? LIM_W : sdsf_pkg::TOTAL_W;
  localparam int SUM_W = sdsf_pkg::TOTAL_W + 1;

  localparam logic [2:0] ST_SWEEP = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_INC   = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_DEC   = 3'd4;

  logic [sdsf_pkg::CNT_W-1:0]   mem [DEPTH];

  logic [2:0]                   st_r, st_nxt;
  logic [ADDR_W-1:0]            swp_r, swp_nxt;
  sdsf_pkg::item_ctl_t          ctl_r;
  logic [ADDR_W-1:0]            addr_r;
  logic [sdsf_pkg::LABEL_W-1:0] label_r;
  logic [sdsf_pkg::CNT_W-1:0]   rd_data_r;
  logic [sdsf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [sdsf_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [sdsf_pkg::THR_W-1:0]   thr_r;
  logic [LIM_W-1:0]             limit_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [sdsf_pkg::EXP_W-1:0]   out_exp_r;
  logic                         out_keep_r;
  logic [sdsf_pkg::LABEL_W-1:0] out_label_r;

  logic                         mem_we, mem_re;
  logic [ADDR_W-1:0]            mem_wa;
  logic [sdsf_pkg::CNT_W-1:0]   mem_wd;
  logic [SUM_W-1:0]             sum;
  logic                         keep, out_free, out_load;

  assign sweep_busy = (st_r == ST_SWEEP);
  assign out_free   = !out_valid_r || out_tready;

  // Saturating bucket increment
  assign cnt_nxt = (rd_data_r == '1) ? rd_data_r : rd_data_r + 1'b1;

  // Running total, restarted on the first repetition, saturating
  always_comb begin
    if (ctl_r.rep_first) begin
      sum = SUM_W'(cnt_r);
    end else begin
      sum = SUM_W'(total_r) + SUM_W'(cnt_r);
    end
    total_nxt = sum[SUM_W-1] ? '1 : sum[sdsf_pkg::TOTAL_W-1:0];
  end

  assign keep = CMP_W'(total_r) <= CMP_W'(limit_r);

  // Sequencer
  always_comb begin
    st_nxt   = st_r;
    swp_nxt  = swp_r;
    q_pop    = 1'b0;
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = addr_r;
    mem_wd   = cnt_nxt;
    out_load = 1'b0;
    unique case (st_r)
      ST_SWEEP: begin
        mem_we  = 1'b1;
        mem_wa  = swp_r;
        mem_wd  = '0;
        swp_nxt = swp_r + 1'b1;
        if (swp_r == ADDR_W'(DEPTH - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        swp_nxt = '0;
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_ctl.is_clear) begin
            st_nxt = ST_SWEEP;
          end else begin
            mem_re = 1'b1;
            st_nxt = ST_INC;
          end
        end
      end
      ST_INC: begin
        mem_we = 1'b1;
        st_nxt = ST_ACC;
      end
      ST_ACC: begin
        st_nxt = ST_DEC;
      end
      ST_DEC: begin
        if (!ctl_r.rep_last) begin
          st_nxt = ST_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_SWEEP;
      swp_r       <= '0;
      total_r     <= '0;
      thr_r       <= sdsf_pkg::THR_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      swp_r       <= swp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (q_pop && q_ctl.is_clear) begin
        total_r <= '0;
      end else if (st_r == ST_ACC) begin
        total_r <= total_nxt;
      end
    end
  end

  // Hold the item in work and the derived limit
  always_ff @(posedge clk) begin
    limit_r <= LIM_W'(thr_r) * LIM_W'(REPS);
    if (q_pop) begin
      ctl_r   <= q_ctl;
      addr_r  <= q_addr;
      label_r <= q_label;
    end
    if (st_r == ST_INC) begin
      cnt_r <= cnt_nxt;
    end
    if (out_load) begin
      out_exp_r   <= ctl_r.exp;
      out_keep_r  <= keep;
      out_label_r <= label_r;
    end
  end

  // Count store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[q_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_label_r;
  assign out_tuser  = {out_keep_r, out_exp_r};

  a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE && !q_empty && q_ctl.is_clear) |=> (st_r == ST_SWEEP))
    else $error("clear did not start a clearing pass");

  a_total_zero_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SWEEP) |-> (total_r == '0))
    else $error("running total not cleared during clearing pass");

  a_result_from_close: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(st_r) == ST_DEC && $past(ctl_r.rep_last)))
    else $error("result raised outside a closing repetition");

endmodule

/* src/sketch_density_sample_filter_unit.sv */
`timescale 1ns / 1ps
// Top level of the sketch density sample filter: front end, queue, back end.
// Depends on sdsf_pkg, sdsf_front, sdsf_queue and sdsf_back.
//
// Usage:
//   in_*  : command stream. tuser holds cmd, experiment, repetition; tdata
//           holds hash_value and label. An add bumps one saturating bucket of
//           the row (experiment, repetition) and adds it to the running total;
//           a clear zeroes every bucket and the total.
//   out_* : one transfer per add on the closing repetition, with the keep
//           decision (total <= keep_threshold * REPS) and the label.
//   cfg_* : write of keep_threshold (reset value 1); write only while idle.
// Path: with the back end idle, the closing add goes through the queue and the
//   back-end states INC, ACC and DEC before out_tvalid rises; when BUCKETS is not
//   a power of two, the front-end remainder steps come first.
// Flow: the back end takes each add through the bucket read-modify-write, total
//   and compare before it pops the next item; with BUCKETS not a power of two the
//   front-end remainder unit holds each add and accepts no new item meanwhile.
// Reset and clear: the store is swept one entry a cycle over all N_EXP*REPS*BUCKETS
//   entries (16384 by default); in_tready stays low for the sweep.
// Stall: the output register holds while out_tready is low; up to 4 commands
//   queue behind it before in_tready drops.
module sketch_density_sample_filter_unit #(
  parameter int N_EXP   = sdsf_pkg::N_EXP_DEF,
  parameter int REPS    = sdsf_pkg::REPS_DEF,
  parameter int BUCKETS = sdsf_pkg::BUCKETS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [31:0] hash_value, [95:32] label
  input  logic [sdsf_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] cmd, [2:1] experiment, [4:3] repetition
  input  logic [sdsf_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [63:0] label_out
  output logic [sdsf_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [1:0] exp_out, [2] keep
  output logic [sdsf_pkg::OUT_USER_W-1:0]  out_tuser,
  input  logic                             cfg_wr_en,
  input  logic [sdsf_pkg::THR_W-1:0]       cfg_wr_data
);

  localparam int ADDR_W = $clog2(N_EXP * REPS * BUCKETS);
  localparam int CTL_W  = $bits(sdsf_pkg::item_ctl_t);
  localparam int QW     = CTL_W + ADDR_W + sdsf_pkg::LABEL_W;

  logic                         f_push, q_full, q_empty, q_pop, sweep_busy;
  sdsf_pkg::item_ctl_t          f_ctl, q_ctl;
  logic [ADDR_W-1:0]            f_addr, q_addr;
  logic [sdsf_pkg::LABEL_W-1:0] f_label, q_label;
  logic [QW-1:0]                q_din, q_dout;

  // Front end: accept and classify
  sdsf_front #(
    .N_EXP   (N_EXP),
    .REPS    (REPS),
    .BUCKETS (BUCKETS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .sweep_busy (sweep_busy),
    .q_full     (q_full),
    .q_push     (f_push),
    .q_ctl      (f_ctl),
    .q_addr     (f_addr),
    .q_label    (f_label)
  );

  // Queue between the two ends
  assign q_din   = {f_ctl, f_addr, f_label};
  assign q_ctl   = sdsf_pkg::item_ctl_t'(q_dout[QW-1 -: CTL_W]);
  assign q_addr  = q_dout[sdsf_pkg::LABEL_W +: ADDR_W];
  assign q_label = q_dout[sdsf_pkg::LABEL_W-1:0];

  sdsf_queue #(
    .W     (QW),
    .DEPTH (sdsf_pkg::Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .full  (q_full)
  );

  // Back end: store update and decision
  sdsf_back #(
    .N_EXP   (N_EXP),
    .REPS    (REPS),
    .BUCKETS (BUCKETS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_ctl       (q_ctl),
    .q_addr      (q_addr),
    .q_label     (q_label),
    .sweep_busy  (sweep_busy),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

/* tb/tb_sketch_density_sample_filter_unit.sv */
`timescale 1ns / 1ps
// Self-checking bench for the sketch density sample filter: a queue-fed stream driver,
// a result monitor and a bit-accurate scoring model of the count store and keep decision.
// Depends on sdsf_pkg and sketch_density_sample_filter_unit.
module tb_sketch_density_sample_filter_unit;

  localparam int N_EXP     = sdsf_pkg::N_EXP_DEF;
  localparam int REPS      = sdsf_pkg::REPS_DEF;
  localparam int BUCKETS   = sdsf_pkg::BUCKETS_DEF;
  localparam int DRAIN_CYC = 64;
  localparam int HOLD_CYC  = 300;
  localparam int N_PHASES  = 8;
  localparam int PHASE_LEN = 205;
  localparam logic [63:0] TOTAL_MAX = (64'd1 << sdsf_pkg::TOTAL_W) - 64'd1;

  // One command of the input stream
  typedef struct packed {
    logic [sdsf_pkg::CMD_W-1:0]   cmd;
    logic [sdsf_pkg::EXP_W-1:0]   exp;
    logic [sdsf_pkg::REP_W-1:0]   rep;
    logic [sdsf_pkg::HASH_W-1:0]  hash;
    logic [sdsf_pkg::LABEL_W-1:0] label;
  } filt_cmd_t;

  // One keep/drop decision
  typedef struct packed {
    logic [sdsf_pkg::EXP_W-1:0]   exp;
    logic                         keep;
    logic [sdsf_pkg::LABEL_W-1:0] label;
  } decision_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [sdsf_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [sdsf_pkg::IN_USER_W-1:0]  in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [sdsf_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [sdsf_pkg::OUT_USER_W-1:0] out_tuser;
  logic                            cfg_wr_en = 1'b0;
  logic [sdsf_pkg::THR_W-1:0]      cfg_wr_data = '0;

  filt_cmd_t   cmd_q[$];
  decision_t   decision_q[$];
  int unsigned bucket_cnt[int unsigned];
  logic [sdsf_pkg::TOTAL_W-1:0] run_total = '0;
  logic [sdsf_pkg::THR_W-1:0]   thr_copy = 32'd1;
  int          fail_cnt = 0;
  logic        in_xfer = 1'b0;
  logic        out_xfer = 1'b0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  bit          long_hold = 1'b0;
  int          in_gap = 0;
  int          out_wait = 0;
  event        hold_start;

  sketch_density_sample_filter_unit #(
    .N_EXP(N_EXP), .REPS(REPS), .BUCKETS(BUCKETS)
  ) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Update the count store copy for one accepted command; queue the decision it makes
  task automatic score_item(input filt_cmd_t it);
    int unsigned slot;
    int unsigned c;
    logic [63:0] tot;
    logic [63:0] lim;
    decision_t   d;
    if (it.cmd == sdsf_pkg::CMD_CLEAR) begin
      bucket_cnt.delete();
      run_total = '0;
      return;
    end
    if (it.exp >= N_EXP || it.rep >= REPS) return;
    slot = (int'(it.exp) * REPS + int'(it.rep)) * BUCKETS + int'(it.hash % BUCKETS);
    c = bucket_cnt.exists(slot) ? bucket_cnt[slot] : 0;
    if (c != 32'hFFFF_FFFF) c = c + 1;
    bucket_cnt[slot] = c;
    tot = (it.rep == 0) ? 64'(c) : 64'(run_total) + 64'(c);
    if (tot > TOTAL_MAX) tot = TOTAL_MAX;
    run_total = tot[sdsf_pkg::TOTAL_W-1:0];
    if (it.rep != REPS - 1) return;
    lim = 64'(thr_copy) * REPS;
    d.exp   = it.exp;
    d.keep  = (tot <= lim);
    d.label = it.label;
    decision_q = {decision_q, d};
  endtask

  // Sample both handshakes; score accepted commands and check transferred decisions
  always @(posedge clk) begin
    decision_t d;
    in_xfer  <= rst_n && in_tvalid && in_tready;
    out_xfer <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      score_item(cmd_q[0]);
      void'(cmd_q.pop_front());
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (decision_q.size() == 0) begin
        $display("%0t: unexpected result exp=%0d keep=%0d label=%h", $time,
                 out_tuser[1:0], out_tuser[2], out_tdata);
        fail_cnt++;
      end else begin
        d = decision_q.pop_front();
        if (out_tuser[1:0] !== d.exp) begin
          $display("%0t: exp_out expected %0d actual %0d", $time, d.exp, out_tuser[1:0]);
          fail_cnt++;
        end
        if (out_tuser[2] !== d.keep) begin
          $display("%0t: keep expected %0d actual %0d", $time, d.keep, out_tuser[2]);
          fail_cnt++;
        end
        if (out_tdata !== d.label) begin
          $display("%0t: label_out expected %h actual %h", $time, d.label, out_tdata);
          fail_cnt++;
        end
      end
    end
  end

  // Drive the input stream from the pending queue, with a random gap per item while input idling is on
  always @(negedge clk) begin
    filt_cmd_t it;
    if (in_xfer) in_gap = in_idle_on ? $urandom_range(0, 7) : 0;
    if (in_tvalid && !in_xfer) begin
      // hold the offered item until it transfers
    end else if (in_gap > 0) begin
      in_gap--;
      in_tvalid <= 1'b0;
    end else if (cmd_q.size() > 0) begin
      it = cmd_q[0];
      in_tvalid <= 1'b1;
      in_tdata  <= {it.label, it.hash};
      in_tuser  <= {it.rep, it.exp, it.cmd};
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Drive out_tready with a random stall per result while output idling is on, or hold it low for a long stretch
  always @(negedge clk) begin
    if (out_xfer) out_wait = out_idle_on ? $urandom_range(0, 7) : 0;
    if (long_hold) begin
      out_tready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Long receiver hold-off so the queue fills and in_tready drops
  always begin
    @(hold_start);
    long_hold = 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    long_hold = 1'b0;
  end

  task automatic push_add(input int e, input int r, input logic [31:0] h,
                          input logic [63:0] l);
    filt_cmd_t it;
    it.cmd   = sdsf_pkg::CMD_ADD;
    it.exp   = e[sdsf_pkg::EXP_W-1:0];
    it.rep   = r[sdsf_pkg::REP_W-1:0];
    it.hash  = h;
    it.label = l;
    cmd_q = {cmd_q, it};
  endtask

  task automatic push_clear();
    filt_cmd_t it;
    it.cmd   = sdsf_pkg::CMD_CLEAR;
    it.exp   = sdsf_pkg::EXP_W'($urandom);
    it.rep   = sdsf_pkg::REP_W'($urandom);
    it.hash  = $urandom;
    it.label = {$urandom, $urandom};
    cmd_q = {cmd_q, it};
  endtask

  // Hashes mostly land on a few hot buckets so counts climb past the threshold
  function automatic logic [31:0] pick_hash();
    logic [31:0] h;
    h = $urandom;
    case ($urandom_range(0, 3))
      0: ;
      1: h[9:0] = 10'($urandom_range(0, 3));
      default: h[9:0] = 10'($urandom_range(0, 31));
    endcase
    return h;
  endfunction

  // Let every command transfer, every decision arrive and the back end go quiet
  task automatic wait_idle();
    while (cmd_q.size() != 0 || decision_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_thr(input logic [31:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    thr_copy = v;
  endtask

  // Mostly whole samples with random content, some broken samples and loose adds
  task automatic gen_phase(input int n_items);
    int n;
    int e;
    int r0;
    int len;
    logic [63:0] l;
    n = 0;
    while (n < n_items) begin
      e = $urandom_range(0, N_EXP - 1);
      l = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        8: begin
          r0  = $urandom_range(0, REPS - 1);
          len = $urandom_range(1, 3);
          for (int k = 0; k < len; k++)
            push_add(e, (r0 + k * $urandom_range(1, 2)) % REPS, pick_hash(), l);
          n += len;
        end
        9: begin
          push_add(e, $urandom_range(0, REPS - 1), $urandom, l);
          n++;
        end
        default: begin
          for (int k = 0; k < REPS; k++) push_add(e, k, pick_hash(), l);
          n += REPS;
        end
      endcase
    end
  endtask

  initial begin
    logic [31:0] thr_set[N_PHASES];
    thr_set = '{32'd0, 32'hFFFF_FFFF, 32'd2, 32'd1, 32'd0, 32'd6, 32'd3, 32'd0};
    thr_set[4] = $urandom_range(0, 20);
    thr_set[7] = $urandom;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: default threshold, both hash extremes, label extremes
    push_add(0, 0, 32'h0, 64'h0);
    push_add(0, 1, 32'h0, 64'h0);
    push_add(0, 2, 32'h0, 64'h0);
    push_add(0, 3, 32'h0, 64'h0);
    for (int k = 0; k < REPS; k++)
      push_add(3, k, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    // same bucket through different high hash bits: total now over the limit
    for (int k = 0; k < REPS; k++)
      push_add(0, k, 32'hFFFF_FC00, 64'h5555_5555_5555_5555);
    // sample entered mid-way: total carries over from the previous one
    push_add(1, 2, 32'h5, 64'h1);
    push_add(1, 3, 32'h5, 64'h8000_0000_0000_0000);
    push_clear();
    // interleaved experiments share the one running total
    push_add(1, 0, 32'h7, 64'h2);
    push_add(2, 1, 32'h7, 64'h3);
    push_add(3, 2, 32'h7, 64'h4);
    push_add(2, 3, 32'h7, 64'hAAAA_AAAA_AAAA_AAAA);
    // repetitions in reverse order
    push_add(0, 3, 32'h3FF, 64'h1234_5678_9ABC_DEF0);
    push_add(0, 2, 32'h3FF, 64'h0);
    push_add(0, 1, 32'h3FF, 64'h0);
    push_add(0, 0, 32'h3FF, 64'h0);
    wait_idle();

    // Random phases, each under its own threshold and idling mix
    for (int p = 0; p < N_PHASES; p++) begin
      write_thr(thr_set[p]);
      in_idle_on  = $urandom_range(0, 3) != 0;
      out_idle_on = $urandom_range(0, 3) != 0;
      if (p == 2 || p == 5) push_clear();
      if (p == 3) begin
        in_idle_on = 1'b0;
        -> hold_start;
      end
      gen_phase(PHASE_LEN);
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
